// File: design/aminv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aminv_pkg
// Shared constants and types for the affine matrix inverse pipeline.
// ----------------------------------------------------------------------------
package aminv_pkg;

	// default fixed-point format, Q16.16
	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;

	// result column codes
	localparam logic [1:0] COL_FIRST = 2'd0;
	localparam logic [1:0] COL_TR    = 2'd3;

	// tag that travels with each quotient through a divider lane
	typedef struct packed {
		logic [1:0] column;
		logic       sing;
		logic       last;
	} aminv_tag_t;

endpackage
`default_nettype wire

// File: design/affine_matrix_inverse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// affine_matrix_inverse
// Inverts a 3x4 fixed-point affine transform by adjugate over determinant.
// Flow: front end, column sequencer, then three divider lanes in lockstep;
//   the first column comes out first and the other three follow one per cycle.
// Busy rises after each accepted start and holds off the next start, spacing
//   transforms by the four result beats; earlier transforms may still be in flight.
// Reset clears valid bits and counters only; the receiver cannot stall.
// ----------------------------------------------------------------------------
module affine_matrix_inverse #(
	parameter int FRAC_BITS = aminv_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = aminv_pkg::WORD_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire logic signed [WORD_BITS-1:0] n_x,
	input  wire logic signed [WORD_BITS-1:0] n_y,
	input  wire logic signed [WORD_BITS-1:0] n_z,
	input  wire logic signed [WORD_BITS-1:0] s_x,
	input  wire logic signed [WORD_BITS-1:0] s_y,
	input  wire logic signed [WORD_BITS-1:0] s_z,
	input  wire logic signed [WORD_BITS-1:0] a_x,
	input  wire logic signed [WORD_BITS-1:0] a_y,
	input  wire logic signed [WORD_BITS-1:0] a_z,
	input  wire logic signed [WORD_BITS-1:0] p_x,
	input  wire logic signed [WORD_BITS-1:0] p_y,
	input  wire logic signed [WORD_BITS-1:0] p_z,
	output logic                             valid,
	output logic [1:0]                       column,
	output logic signed [WORD_BITS-1:0]      out_x,
	output logic signed [WORD_BITS-1:0]      out_y,
	output logic signed [WORD_BITS-1:0]      out_z,
	output logic                             singular,
	output logic                             last
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int CW = 2*W + 1;
	localparam int SW = 3*W + 2;
	localparam int NL = CW + 2*F;
	localparam int NT = SW + F;
	localparam int NW = (NL > NT) ? NL : NT;

	logic                  accept;
	logic [1:0]            busy_cnt_q;

	logic signed [W-1:0]   m_in [12];
	logic                  fr_valid;
	logic signed [SW-1:0]  fr_det;
	logic signed [CW-1:0]  fr_cof [9];
	logic signed [SW-1:0]  fr_ndot [3];

	logic                  act_q;
	logic [1:0]            col_q;
	logic signed [SW-1:0]  det_q;
	logic signed [CW-1:0]  cof_q [3][3];
	logic signed [SW-1:0]  ndot_q [3];
	logic                  sing_q;

	logic [1:0]            cidx;
	aminv_pkg::aminv_tag_t feed_tag;
	logic signed [NW-1:0]  num [3];

	logic                  ln_valid [3];
	aminv_pkg::aminv_tag_t ln_tag [3];
	logic signed [W-1:0]   ln_quo [3];

	// input handshake: a start is accepted only while busy is low
	assign accept = start && !busy;
	assign busy   = (busy_cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_cnt_q <= 2'd0;
		end else if (accept) begin
			busy_cnt_q <= 2'd3;
		end else if (busy) begin
			busy_cnt_q <= busy_cnt_q - 2'd1;
		end
	end

	assign m_in = '{n_x, n_y, n_z, s_x, s_y, s_z, a_x, a_y, a_z, p_x, p_y, p_z};

	aminv_front #(
		.W(W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.m_in     (m_in),
		.out_valid(fr_valid),
		.det      (fr_det),
		.cof      (fr_cof),
		.ndot     (fr_ndot)
	);

	// column sequencer over the held front-end result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			col_q <= aminv_pkg::COL_FIRST;
		end else if (fr_valid) begin
			act_q <= 1'b1;
			col_q <= aminv_pkg::COL_FIRST;
		end else if (act_q) begin
			col_q <= col_q + 2'd1;
			if (col_q == aminv_pkg::COL_TR) begin
				act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fr_valid) begin
			det_q  <= fr_det;
			sing_q <= (fr_det == '0);
			ndot_q <= fr_ndot;
			for (int k = 0; k < 3; k++) begin
				for (int c = 0; c < 3; c++) begin
					cof_q[k][c] <= fr_cof[k*3+c];
				end
			end
		end
	end

	// numerators for the current column
	assign cidx = (col_q == aminv_pkg::COL_TR) ? aminv_pkg::COL_FIRST : col_q;

	always_comb begin
		feed_tag.column = col_q;
		feed_tag.sing   = sing_q;
		feed_tag.last   = (col_q == aminv_pkg::COL_TR);
	end

	for (genvar k = 0; k < 3; k++) begin : g_lane
		always_comb begin
			if (col_q == aminv_pkg::COL_TR) begin
				num[k] = NW'(ndot_q[k]) <<< F;
			end else begin
				num[k] = NW'(cof_q[k][cidx]) <<< (2*F);
			end
		end

		aminv_div #(
			.W (W),
			.NW(NW),
			.DW(SW)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (act_q),
			.in_tag   (feed_tag),
			.num      (num[k]),
			.den      (det_q),
			.out_valid(ln_valid[k]),
			.out_tag  (ln_tag[k]),
			.quo      (ln_quo[k])
		);
	end

	// result beat
	assign valid    = ln_valid[0];
	assign column   = ln_tag[0].column;
	assign singular = ln_tag[0].sing;
	assign last     = ln_tag[0].last;
	assign out_x    = ln_quo[0];
	assign out_y    = ln_quo[1];
	assign out_z    = ln_quo[2];

	// lanes stay in lockstep
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(ln_valid[0] == ln_valid[1]) && (ln_valid[0] == ln_valid[2]) &&
		(!ln_valid[0] || ((ln_tag[0] == ln_tag[1]) && (ln_tag[0] == ln_tag[2]))))
		else $error("divider lanes out of step");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && singular |-> (out_x == '0) && (out_y == '0) && (out_z == '0))
		else $error("singular beat with nonzero components");

	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (last == (column == aminv_pkg::COL_TR)))
		else $error("last flag not on translation column");

	a_col_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (column != aminv_pkg::COL_FIRST) |->
		$past(valid) && (column == $past(column) + 2'd1))
		else $error("result columns out of order");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after accepted start");

endmodule
`default_nettype wire

// File: design/aminv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aminv_front
// Exact cofactors, determinant and negated translation dot products.
// Seven register stages, one item may enter every cycle.
// ----------------------------------------------------------------------------
module aminv_front #(
	parameter int W = aminv_pkg::WORD_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire logic signed [W-1:0]     m_in [12],
	output logic                         out_valid,
	output logic signed [3*W+1:0]        det,
	output logic signed [2*W:0]          cof [9],
	output logic signed [3*W+1:0]        ndot [3]
);

	localparam int CW = 2*W + 1;  // cofactor width
	localparam int SW = 3*W + 2;  // dot product width
	localparam int PW = 2*W + 1;  // partial product width

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [W-1:0]    m_s1 [12];
	logic signed [2*W-1:0]  pa_s2 [9];
	logic signed [2*W-1:0]  pb_s2 [9];
	logic signed [W-1:0]    n_s2 [3];
	logic signed [W-1:0]    p_s2 [3];
	logic signed [CW-1:0]   cof_s3 [9];
	logic signed [W-1:0]    n_s3 [3];
	logic signed [W-1:0]    p_s3 [3];
	logic signed [PW-1:0]   plo_s4 [12];
	logic signed [PW-1:0]   phi_s4 [12];
	logic signed [CW-1:0]   cof_s4 [9];
	logic signed [SW-1:0]   term_s5 [12];
	logic signed [CW-1:0]   cof_s5 [9];
	logic signed [SW-1:0]   sum_s6 [4];
	logic signed [CW-1:0]   cof_s6 [9];
	logic signed [SW-1:0]   det_s7;
	logic signed [SW-1:0]   ndot_s7 [3];
	logic signed [CW-1:0]   cof_s7 [9];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// s1: capture the beat
	always_ff @(posedge clk) begin
		if (in_valid) begin
			m_s1 <= m_in;
		end
	end

	// s2: cross product terms; cof0 = s x a, cof1 = a x n, cof2 = n x s
	for (genvar k = 0; k < 3; k++) begin : g_cross
		localparam int UB = (k == 0) ? 3 : ((k == 1) ? 6 : 0);
		localparam int VB = (k == 0) ? 6 : ((k == 1) ? 0 : 3);
		for (genvar c = 0; c < 3; c++) begin : g_comp
			localparam int I1 = (c + 1) % 3;
			localparam int I2 = (c + 2) % 3;
			always_ff @(posedge clk) begin
				pa_s2[k*3+c] <= m_s1[UB+I1] * m_s1[VB+I2];
				pb_s2[k*3+c] <= m_s1[UB+I2] * m_s1[VB+I1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			n_s2[i] <= m_s1[i];
			p_s2[i] <= m_s1[9+i];
		end
	end

	// s3: cofactors
	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			cof_s3[i] <= CW'(pa_s2[i]) - CW'(pb_s2[i]);
		end
		n_s3 <= n_s2;
		p_s3 <= p_s2;
	end

	// s4: split products; terms 0..2 feed det, 3..11 the translation dots
	for (genvar t = 0; t < 12; t++) begin : g_pp
		localparam int CI = (t < 3) ? t : (t - 3);
		localparam int XI = (t < 3) ? t : ((t - 3) % 3);
		logic signed [W-1:0] x_op;
		assign x_op = (t < 3) ? n_s3[XI] : p_s3[XI];
		always_ff @(posedge clk) begin
			plo_s4[t] <= x_op * $signed({1'b0, cof_s3[CI][W-1:0]});
			phi_s4[t] <= x_op * $signed(cof_s3[CI][CW-1:W]);
		end
	end

	always_ff @(posedge clk) begin
		cof_s4 <= cof_s3;
	end

	// s5: recombine the halves
	always_ff @(posedge clk) begin
		for (int t = 0; t < 12; t++) begin
			term_s5[t] <= (SW'(phi_s4[t]) <<< W) + SW'(plo_s4[t]);
		end
		cof_s5 <= cof_s4;
	end

	// s6: three-term sums
	always_ff @(posedge clk) begin
		for (int g = 0; g < 4; g++) begin
			sum_s6[g] <= term_s5[3*g] + term_s5[3*g+1] + term_s5[3*g+2];
		end
		cof_s6 <= cof_s5;
	end

	// s7: determinant and negated translation numerators
	always_ff @(posedge clk) begin
		det_s7 <= sum_s6[0];
		for (int j = 0; j < 3; j++) begin
			ndot_s7[j] <= -sum_s6[j+1];
		end
		cof_s7 <= cof_s6;
	end

	assign out_valid = vld_s7;
	assign det       = det_s7;
	assign cof       = cof_s7;
	assign ndot      = ndot_s7;

endmodule
`default_nettype wire

// File: design/aminv_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aminv_div
// Pipelined signed restoring divider, one quotient bit per stage,
// truncated toward zero and saturated to W bits.
// ----------------------------------------------------------------------------
module aminv_div #(
	parameter int W  = aminv_pkg::WORD_BITS_DEF,
	parameter int NW = 4*W,
	parameter int DW = 3*W + 2
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	input  wire aminv_pkg::aminv_tag_t in_tag,
	input  wire logic signed [NW-1:0] num,
	input  wire logic signed [DW-1:0] den,
	output logic                      out_valid,
	output aminv_pkg::aminv_tag_t     out_tag,
	output logic signed [W-1:0]       quo
);

	localparam int RW = (NW > DW + W) ? NW : (DW + W);
	localparam int NS = W - 1;  // quotient bits below the saturation limit

	logic                  vld_s1;
	aminv_pkg::aminv_tag_t tag_s1;
	logic                  neg_s1;
	logic [NW-1:0]         an_s1;
	logic [DW-1:0]         ad_s1;

	logic                  vld_sn [NS+1];
	aminv_pkg::aminv_tag_t tag_sn [NS+1];
	logic                  neg_sn [NS+1];
	logic                  sat_sn [NS+1];
	logic [RW-1:0]         rem_sn [NS+1];
	logic [DW-1:0]         ad_sn  [NS+1];
	logic [NS-1:0]         quo_sn [NS+1];

	logic                  vld_q;
	aminv_pkg::aminv_tag_t tag_q;
	logic signed [W-1:0]   quo_q;

	logic [W-1:0]          mag;
	logic signed [W-1:0]   res;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int j = 0; j <= NS; j++) begin
				vld_sn[j] <= 1'b0;
			end
			vld_q <= 1'b0;
		end else begin
			vld_s1    <= in_valid;
			vld_sn[0] <= vld_s1;
			for (int j = 0; j < NS; j++) begin
				vld_sn[j+1] <= vld_sn[j];
			end
			vld_q <= vld_sn[NS];
		end
	end

	// s1: magnitudes and quotient sign
	always_ff @(posedge clk) begin
		tag_s1 <= in_tag;
		neg_s1 <= num[NW-1] ^ den[DW-1];
		an_s1  <= num[NW-1] ? NW'(-num) : NW'(num);
		ad_s1  <= den[DW-1] ? DW'(-den) : DW'(den);
	end

	// first step stage: saturation check against den << (W-1)
	always_ff @(posedge clk) begin
		tag_sn[0] <= tag_s1;
		neg_sn[0] <= neg_s1;
		sat_sn[0] <= RW'(an_s1) >= (RW'(ad_s1) << (W-1));
		rem_sn[0] <= RW'(an_s1);
		ad_sn[0]  <= ad_s1;
		quo_sn[0] <= '0;
	end

	// restoring steps, most significant quotient bit first
	for (genvar j = 0; j < NS; j++) begin : g_step
		localparam int SH = NS - 1 - j;
		logic [RW-1:0] dsh;
		logic          take;
		assign dsh  = RW'(ad_sn[j]) << SH;
		assign take = rem_sn[j] >= dsh;
		always_ff @(posedge clk) begin
			tag_sn[j+1] <= tag_sn[j];
			neg_sn[j+1] <= neg_sn[j];
			sat_sn[j+1] <= sat_sn[j];
			ad_sn[j+1]  <= ad_sn[j];
			rem_sn[j+1] <= take ? (rem_sn[j] - dsh) : rem_sn[j];
			quo_sn[j+1] <= {quo_sn[j][NS-2:0], take};
		end
	end

	// sign, saturation and singular override
	assign mag = {1'b0, quo_sn[NS]};
	always_comb begin
		if (tag_sn[NS].sing) begin
			res = '0;
		end else if (sat_sn[NS]) begin
			res = neg_sn[NS] ? $signed({1'b1, {(W-1){1'b0}}}) : $signed({1'b0, {(W-1){1'b1}}});
		end else if (neg_sn[NS]) begin
			res = $signed(-mag);
		end else begin
			res = $signed(mag);
		end
	end

	always_ff @(posedge clk) begin
		tag_q <= tag_sn[NS];
		quo_q <= res;
	end

	assign out_valid = vld_q;
	assign out_tag   = tag_q;
	assign quo       = quo_q;

endmodule
`default_nettype wire

// File: dv/affine_matrix_inverse_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affine_matrix_inverse_checker
// Watches the command and result channels of the affine inverse block,
// computes the four inverse columns of every accepted transform exactly
// and compares each result beat against the oldest predicted column.
// ----------------------------------------------------------------------------
module affine_matrix_inverse_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire               busy,
	input  wire signed [31:0] n_x,
	input  wire signed [31:0] n_y,
	input  wire signed [31:0] n_z,
	input  wire signed [31:0] s_x,
	input  wire signed [31:0] s_y,
	input  wire signed [31:0] s_z,
	input  wire signed [31:0] a_x,
	input  wire signed [31:0] a_y,
	input  wire signed [31:0] a_z,
	input  wire signed [31:0] p_x,
	input  wire signed [31:0] p_y,
	input  wire signed [31:0] p_z,
	input  wire               valid,
	input  wire [1:0]         column,
	input  wire signed [31:0] out_x,
	input  wire signed [31:0] out_y,
	input  wire signed [31:0] out_z,
	input  wire               singular,
	input  wire               last,
	output int                errors,
	output int                pending
);

	localparam int FRAC = aminv_pkg::FRAC_BITS_DEF;

	typedef logic signed [159:0] wide_t;

	typedef struct packed {
		logic [1:0]         column;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               sing;
		logic               last;
	} inv_col_t;

	inv_col_t inv_cols[$];

	assign pending = inv_cols.size();

	// truncated quotient, clamped to 32-bit signed
	function automatic logic signed [31:0] quot_sat(input wide_t num, input wide_t den);
		wide_t q;
		q = num / den;
		if (q > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (q < -64'sh8000_0000) return 32'sh8000_0000;
		return q[31:0];
	endfunction

	task automatic predict_inverse();
		wide_t m[3][3];
		wide_t t[3];
		wide_t cof[3][3];
		wide_t det;
		wide_t num;
		inv_col_t c;
		m[0][0] = n_x; m[0][1] = n_y; m[0][2] = n_z;
		m[1][0] = s_x; m[1][1] = s_y; m[1][2] = s_z;
		m[2][0] = a_x; m[2][1] = a_y; m[2][2] = a_z;
		t[0] = p_x; t[1] = p_y; t[2] = p_z;
		// cof[k] = cross of the other two linear columns, cyclic
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				cof[k][j] = m[(k+1)%3][(j+1)%3] * m[(k+2)%3][(j+2)%3]
					- m[(k+1)%3][(j+2)%3] * m[(k+2)%3][(j+1)%3];
			end
		end
		det = m[0][0]*cof[0][0] + m[0][1]*cof[0][1] + m[0][2]*cof[0][2];
		for (int col = 0; col < 4; col++) begin
			c.column = col[1:0];
			c.sing = (det == 0);
			c.last = (col == 3);
			c.x = '0; c.y = '0; c.z = '0;
			if (det != 0) begin
				for (int k = 0; k < 3; k++) begin
					if (col < 3) num = cof[k][col] <<< (2*FRAC);
					else num = -(t[0]*cof[k][0] + t[1]*cof[k][1] + t[2]*cof[k][2]) <<< FRAC;
					case (k)
						0: c.x = quot_sat(num, det);
						1: c.y = quot_sat(num, det);
						default: c.z = quot_sat(num, det);
					endcase
				end
			end
			inv_cols.push_back(c);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk) begin
		inv_col_t e;
		if (arst_n) begin
			if (valid) begin
				if (inv_cols.size() == 0) begin
					report_mismatch("unexpected beat", column, 0);
				end else begin
					e = inv_cols.pop_front();
					if (column !== e.column) report_mismatch("column", column, e.column);
					if (out_x !== e.x) report_mismatch("out_x", out_x, e.x);
					if (out_y !== e.y) report_mismatch("out_y", out_y, e.y);
					if (out_z !== e.z) report_mismatch("out_z", out_z, e.z);
					if (singular !== e.sing) report_mismatch("singular", singular, e.sing);
					if (last !== e.last) report_mismatch("last", last, e.last);
				end
			end
			if (start && !busy) predict_inverse();
		end
	end
endmodule
`default_nettype wire

// File: dv/tb_affine_matrix_inverse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_affine_matrix_inverse
// Drives directed and random affine transforms into the inverse block with
// random start gaps; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_affine_matrix_inverse;
	localparam int N_RANDOM = 460;
	localparam int DRAIN    = 60;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] fld[12];
	logic               valid;
	logic [1:0]         column;
	logic signed [31:0] out_x, out_y, out_z;
	logic               singular, last;
	int                 errors, pending;

	affine_matrix_inverse u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.n_x(fld[0]), .n_y(fld[1]), .n_z(fld[2]),
		.s_x(fld[3]), .s_y(fld[4]), .s_z(fld[5]),
		.a_x(fld[6]), .a_y(fld[7]), .a_z(fld[8]),
		.p_x(fld[9]), .p_y(fld[10]), .p_z(fld[11]),
		.valid(valid), .column(column), .out_x(out_x), .out_y(out_y),
		.out_z(out_z), .singular(singular), .last(last)
	);

	affine_matrix_inverse_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.n_x(fld[0]), .n_y(fld[1]), .n_z(fld[2]),
		.s_x(fld[3]), .s_y(fld[4]), .s_z(fld[5]),
		.a_x(fld[6]), .a_y(fld[7]), .a_z(fld[8]),
		.p_x(fld[9]), .p_y(fld[10]), .p_z(fld[11]),
		.valid(valid), .column(column), .out_x(out_x), .out_y(out_y),
		.out_z(out_z), .singular(singular), .last(last),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	// random field value, biased toward edges and small Q16.16 magnitudes
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sd0;
			3, 4, 5: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			default: return $urandom;
		endcase
	endfunction

	// present one transform and hold it until the accepting edge;
	// start stays high so the next beat can follow without a gap
	task automatic send_transform(input logic signed [31:0] v[12]);
		start <= 1'b1;
		for (int i = 0; i < 12; i++) fld[i] <= v[i];
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic idle_burst(input bit allow);
		int n;
		if (allow && $urandom_range(0, 2) == 0) begin
			n = $urandom_range(1, 15);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	initial begin
		logic signed [31:0] v[12];
		int wait_cnt;
		arst_n = 1'b0;
		start = 1'b0;
		for (int i = 0; i < 12; i++) fld[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity, scaled, singular, extremes, alternating bit patterns, random fills
		for (int d = 0; d < 20; d++) begin
			for (int i = 0; i < 12; i++) v[i] = 0;
			case (d)
				0: begin v[0] = 32'sh1_0000; v[4] = 32'sh1_0000; v[8] = 32'sh1_0000; end
				1: begin v[0] = 32'sh2_0000; v[4] = -32'sh4_0000; v[8] = 32'sh8000;
					v[9] = 32'sh3_0000; v[10] = -32'sh1_8000; v[11] = 32'sh7FFF_FFFF; end
				2: ; // all zero, singular
				3: for (int i = 0; i < 12; i++) v[i] = 32'sh7FFF_FFFF;
				4: for (int i = 0; i < 12; i++) v[i] = 32'sh8000_0000;
				5: begin v[0] = 1; v[4] = 1; v[8] = 1; v[9] = 32'sh7FFF_FFFF;
					v[10] = 32'sh8000_0000; v[11] = -1; end
				6: begin v[0] = 32'sh7FFF_FFFF; v[4] = 32'sh8000_0000; v[8] = 32'sh7FFF_FFFF;
					v[9] = 32'sh8000_0000; end
				7: begin v[1] = 32'sh1_0000; v[3] = -32'sh1_0000; v[8] = 32'sh1_0000;
					v[9] = 32'sh5_0000; end
				8: begin // rank two: third column is sum of first two
					v[0] = 32'sh1_0000; v[1] = 32'sh2_0000; v[3] = 32'sh3_0000;
					v[4] = 32'sh1_0000; v[6] = 32'sh4_0000; v[7] = 32'sh3_0000; end
				9: for (int i = 0; i < 12; i++) v[i] = -1;
				10: for (int i = 0; i < 12; i++) v[i] = (i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA;
				11: for (int i = 0; i < 12; i++) v[i] = (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555;
				default: for (int i = 0; i < 12; i++) v[i] = pick_value();
			endcase
			send_transform(v);
			idle_burst(1'b1);
		end

		// pause until all results are back
		start <= 1'b0;
		@(posedge clk);
		wait_cnt = 0;
		while (pending != 0 && wait_cnt < 10000) begin
			@(posedge clk);
			wait_cnt++;
		end

		// random transforms; last part without gaps
		for (int r = 0; r < N_RANDOM; r++) begin
			for (int i = 0; i < 12; i++) v[i] = pick_value();
			if ($urandom_range(0, 15) == 0) begin
				for (int i = 0; i < 3; i++) v[6 + i] = v[i]; // repeated column
			end
			send_transform(v);
			idle_burst(r < N_RANDOM - 80 && (r / 40) % 3 != 2);
		end

		start <= 1'b0;
		@(posedge clk);
		wait_cnt = 0;
		while (pending != 0 && wait_cnt < 10000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (DRAIN) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
design/aminv_pkg.sv
design/aminv_front.sv
design/aminv_div.sv
design/affine_matrix_inverse.sv
dv/affine_matrix_inverse_checker.sv
dv/tb_affine_matrix_inverse.sv
